// ===== rtl/edf_pkg.sv =====
// Shared constants, codes and types of the 3x3 streaming edge filter.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int IN_ROW_W    = 13;
   localparam int OUT_ROW_W   = 12;
   localparam int PIX_W       = 8;
   localparam int MODE_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [MODE_W-1:0] MODE_SOBEL       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PREWITT     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LAPLACE     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LAPLACE_ALT = 2'd3;

   localparam logic [1:0] REG_EDGE_MODE    = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } mask_type;

   typedef struct packed {
      pix_type [2:0][2:0] taps;
      logic               eof;
   } taps_type;

endpackage

`default_nettype wire

// ===== rtl/edf_front.sv =====
// Front part of the edge filter: accepts items, tracks raster position, keeps the
// line stores and the 3x3 window, and pushes masked windows. Depends on edf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edf_front import edf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire geom_type          geom,
   input  wire logic              restart,
   input  wire logic              req_valid,
   input  wire logic              req_action,
   input  wire logic [PIX_W-1:0]  req_pixel_value,
   output logic                   req_stall,
   input  wire logic [QCNT_W-1:0] q_count,
   output logic                   q_push,
   output taps_type               q_data
);

   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic                 started_ff, started_in;

   logic                 b_valid_ff;
   pix_type              b_pix_ff;
   logic [COL_W-1:0]     b_col_ff;
   logic                 b_emit_ff;
   mask_type             b_mask_ff;
   logic                 b_eof_ff;
   logic                 bypass_hit_ff;
   logic [2*PIX_W-1:0]   bypass_ff;
   logic [2*PIX_W-1:0]   rd_data_ff;
   logic [2*PIX_W-1:0]   line_ram [MAX_WIDTH];

   pix_type [2:0][2:0]   win_ff, win_in;

   logic                 accept;
   pix_type              pix_a;
   mask_type             mask_a;
   logic                 eof_a;
   logic                 at_start;
   logic                 in_right;
   logic [QCNT_W:0]      pending;
   logic [2*PIX_W-1:0]   line_rd;
   logic [2*PIX_W-1:0]   wr_data;

   assign pending   = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(b_valid_ff && b_emit_ff);
   assign req_stall = reset || (pending >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign pix_a         = req_action ? '0 : req_pixel_value;
   assign at_start      = (in_row_ff == IN_ROW_W'(1)) && (in_col_ff == '0);
   assign in_right      = (WIDTH_W'(in_col_ff) + WIDTH_W'(1)) >= geom.width;
   assign mask_a.top    = (out_row_ff == '0);
   assign mask_a.bottom = (HEIGHT_W'(out_row_ff) + HEIGHT_W'(1)) >= geom.height;
   assign mask_a.left   = (out_col_ff == '0);
   assign mask_a.right  = (WIDTH_W'(out_col_ff) + WIDTH_W'(1)) >= geom.width;
   assign eof_a         = mask_a.bottom && mask_a.right;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      started_in = started_ff;
      if (restart || (accept && started_ff && eof_a)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         started_in = 1'b0;
      end else if (accept) begin
         if (started_ff) begin
            if (mask_a.right) begin
               out_col_in = '0;
               if (out_row_ff != '1) begin
                  out_row_in = out_row_ff + OUT_ROW_W'(1);
               end
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
         if (in_right) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + IN_ROW_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (at_start) begin
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         started_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         started_ff <= started_in;
         b_valid_ff <= accept;
      end
   end

   // A write from the second stage to the column being read now is not seen
   // by the read, so its data is carried along instead.
   assign line_rd = bypass_hit_ff ? bypass_ff : rd_data_ff;
   assign wr_data = {line_rd[PIX_W-1:0], b_pix_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff    <= line_ram[in_col_ff];
         b_pix_ff      <= pix_a;
         b_col_ff      <= in_col_ff;
         b_emit_ff     <= started_ff;
         b_mask_ff     <= mask_a;
         b_eof_ff      <= eof_a;
         bypass_hit_ff <= b_valid_ff && (b_col_ff == in_col_ff);
         bypass_ff     <= wr_data;
      end
      if (b_valid_ff) begin
         line_ram[b_col_ff] <= wr_data;
      end
   end

   always_comb begin
      win_in = win_ff;
      if (restart) begin
         win_in = '0;
      end else if (b_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = line_rd[2*PIX_W-1:PIX_W];
         win_in[1][2] = line_rd[PIX_W-1:0];
         win_in[2][2] = b_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      q_data.eof = b_eof_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && b_mask_ff.top) || (r == 2 && b_mask_ff.bottom) ||
                (c == 0 && b_mask_ff.left) || (c == 2 && b_mask_ff.right)) begin
               q_data.taps[r][c] = '0;
            end else begin
               q_data.taps[r][c] = win_in[r][c];
            end
         end
      end
   end

   assign q_push = b_valid_ff && b_emit_ff;

endmodule

`default_nettype wire

// ===== rtl/edf_queue.sv =====
// Short queue of masked windows between the front and back parts.
// Depends on edf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edf_queue import edf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire taps_type          push_data,
   input  wire logic              pop,
   output taps_type               pop_data,
   output logic                   not_empty,
   output logic [QCNT_W-1:0]      count
);

   taps_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign pop_data  = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCNT_W'(QUEUE_DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/edf_back.sv =====
// Back part of the edge filter: kernel sums, magnitude clamps and the result
// register. Depends on edf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edf_back import edf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [MODE_W-1:0] mode,
   input  wire logic              q_valid,
   input  wire taps_type          q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PIX_W-1:0]       rsp_edge_value,
   output logic [PIX_W-1:0]       rsp_x_part,
   output logic [PIX_W-1:0]       rsp_y_part,
   output logic                   rsp_end_of_frame
);

   localparam int SUM_W = 13;

   function automatic logic signed [SUM_W-1:0] ext(input pix_type p);
      return signed'(SUM_W'(p));
   endfunction

   function automatic pix_type clamp_abs(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] mag;
      mag = (v < 0) ? -v : v;
      return (mag > SUM_W'(255)) ? pix_type'(255) : mag[PIX_W-1:0];
   endfunction

   function automatic pix_type clamp_pos(input logic signed [SUM_W-1:0] v);
      if (v < 0) begin
         return '0;
      end
      return (v > SUM_W'(255)) ? pix_type'(255) : v[PIX_W-1:0];
   endfunction

   logic                    s1_valid_ff;
   logic signed [SUM_W-1:0] s1_gx_ff, s1_gx_in;
   logic signed [SUM_W-1:0] s1_gy_ff, s1_gy_in;
   logic signed [SUM_W-1:0] s1_lap_ff, s1_lap_in;
   logic                    s1_eof_ff;

   logic                    rsp_valid_ff;
   pix_type                 edge_ff, edge_in;
   pix_type                 x_ff, x_in;
   pix_type                 y_ff, y_in;
   logic                    eof_ff;

   logic                    out_free;
   logic                    s1_adv;
   logic                    is_lap;
   logic                    is_sobel;
   logic [PIX_W:0]          grad_sum;

   assign is_lap   = (mode == MODE_LAPLACE) || (mode == MODE_LAPLACE_ALT);
   assign is_sobel = (mode == MODE_SOBEL);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_adv   = !s1_valid_ff || out_free;
   assign q_pop    = q_valid && s1_adv;

   always_comb begin
      logic signed [SUM_W-1:0] dx0, dx1, dx2, dy0, dy1, dy2, ring;
      dx0 = ext(q_data.taps[0][2]) - ext(q_data.taps[0][0]);
      dx1 = ext(q_data.taps[1][2]) - ext(q_data.taps[1][0]);
      dx2 = ext(q_data.taps[2][2]) - ext(q_data.taps[2][0]);
      dy0 = ext(q_data.taps[2][0]) - ext(q_data.taps[0][0]);
      dy1 = ext(q_data.taps[2][1]) - ext(q_data.taps[0][1]);
      dy2 = ext(q_data.taps[2][2]) - ext(q_data.taps[0][2]);
      ring = ext(q_data.taps[0][0]) + ext(q_data.taps[0][1]) + ext(q_data.taps[0][2])
           + ext(q_data.taps[1][0]) + ext(q_data.taps[1][2])
           + ext(q_data.taps[2][0]) + ext(q_data.taps[2][1]) + ext(q_data.taps[2][2]);
      s1_gx_in  = dx0 + dx2 + (is_sobel ? (dx1 + dx1) : dx1);
      s1_gy_in  = dy0 + dy2 + (is_sobel ? (dy1 + dy1) : dy1);
      s1_lap_in = (ext(q_data.taps[1][1]) <<< 3) - ring;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_gx_ff  <= s1_gx_in;
         s1_gy_ff  <= s1_gy_in;
         s1_lap_ff <= s1_lap_in;
         s1_eof_ff <= q_data.eof;
      end
   end

   always_comb begin
      if (is_lap) begin
         x_in     = '0;
         y_in     = '0;
         grad_sum = '0;
         edge_in  = clamp_pos(s1_lap_ff);
      end else begin
         x_in     = clamp_abs(s1_gx_ff);
         y_in     = clamp_abs(s1_gy_ff);
         grad_sum = (PIX_W + 1)'(x_in) + (PIX_W + 1)'(y_in);
         edge_in  = grad_sum[PIX_W] ? pix_type'(255) : grad_sum[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         edge_ff <= edge_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         eof_ff  <= s1_eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_edge_value   = edge_ff;
   assign rsp_x_part       = x_ff;
   assign rsp_y_part       = y_ff;
   assign rsp_end_of_frame = eof_ff;

   a_lap_no_parts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && is_lap) |-> (x_ff == '0 && y_ff == '0))
      else $error("gradient parts nonzero in Laplace mode");

   a_sum_covers_parts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !is_lap) |-> (edge_ff >= x_ff && edge_ff >= y_ff))
      else $error("combined magnitude below one of its parts");

endmodule

`default_nettype wire

// ===== rtl/edge_detect_3x3_stream.sv =====
// Top level of the 3x3 streaming edge filter: register port, front, queue, back.
// Depends on edf_pkg, edf_front, edf_queue and edf_back.
//
//   Channel  Direction  Handshake              Content
//   req      in         req_valid / req_stall  action, pixel_value
//   rsp      out        rsp_valid / rsp_stall  edge_value, x_part, y_part, end_of_frame
//   csr      in/out     csr_psel / csr_penable edge_mode, frame_width, frame_height
//
// One item is taken per clock while req_stall is low; the line store has one read and one write port,
// and each item does one read and one write of it.
// The result for pixel i is caused by item i + W + 1; it then passes the queue,
// the sum register and the result register.
// Reset clears the counters and the window; the line store is not cleared.
// req_stall is high during reset and when the queue between front and back,
// counting the window about to enter it, is full.
`timescale 1ns / 1ps
`default_nettype none

module edge_detect_3x3_stream import edf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   input  wire logic [PIX_W-1:0]  req_pixel_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [PIX_W-1:0]       rsp_edge_value,
   output logic [PIX_W-1:0]       rsp_x_part,
   output logic [PIX_W-1:0]       rsp_y_part,
   output logic                   rsp_end_of_frame,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [MODE_W-1:0]   mode_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;

   logic                csr_wr;
   logic [1:0]          csr_index;
   logic                restart;
   geom_type            geom;

   logic                q_push;
   taps_type            q_push_data;
   logic                q_pop;
   taps_type            q_pop_data;
   logic                q_not_empty;
   logic [QCNT_W-1:0]   q_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];
   assign restart    = csr_wr &&
                       (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SOBEL;
         width_ff  <= WIDTH_W'(1024);
         height_ff <= HEIGHT_W'(1024);
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_EDGE_MODE:    mode_ff   <= csr_pwdata[MODE_W-1:0];
            REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[WIDTH_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_pwdata[HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_EDGE_MODE:    csr_prdata = DATA_W'(mode_ff);
         REG_FRAME_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      priority if (width_ff == '0) begin
         geom.width = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         geom.width = WIDTH_W'(MAX_WIDTH);
      end else begin
         geom.width = width_ff;
      end
      priority if (height_ff == '0) begin
         geom.height = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         geom.height = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         geom.height = height_ff;
      end
   end

   edf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .restart         (restart),
      .req_valid       (req_valid),
      .req_action      (req_action),
      .req_pixel_value (req_pixel_value),
      .req_stall       (req_stall),
      .q_count         (q_count),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   edf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   edf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .mode             (mode_ff),
      .q_valid          (q_not_empty),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_edge_value   (rsp_edge_value),
      .rsp_x_part       (rsp_x_part),
      .rsp_y_part       (rsp_y_part),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

// ===== tb/edge_detect_3x3_stream_tb.sv =====
// Self-checking testbench for the 3x3 streaming edge filter edge_detect_3x3_stream.
// Drives pixel and flush items and register writes; a scoreboard predicts each result.
// Depends on edf_pkg and the RTL of edge_detect_3x3_stream.
`timescale 1ns / 1ps

module edge_detect_3x3_stream_tb import edf_pkg::*; ;

   localparam logic        ACT_PIXEL   = 1'b0;
   localparam logic        ACT_FLUSH   = 1'b1;
   localparam int          IDLE_PAD    = 12;
   localparam int          DRAIN_PAD   = 20;
   localparam int          LONG_HOLD   = 300;
   localparam int          RANDOM_GOAL = 650;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      pix_type edge_value;
      pix_type x_part;
      pix_type y_part;
      logic    end_of_frame;
   } edge_result_type;

   class edge_scoreboard;
      bit [MODE_W-1:0]   mode;
      bit [WIDTH_W-1:0]  width_reg;
      bit [HEIGHT_W-1:0] height_reg;
      pix_type           upper_row [MAX_WIDTH];
      pix_type           middle_row [MAX_WIDTH];
      pix_type           window [3][3];
      int unsigned       in_col, in_row, out_col, out_row;
      bit                streaming;
      edge_result_type   expected_edges [$];
      int                failures;

      function new();
         mode = MODE_SOBEL;
         width_reg = WIDTH_W'(1024);
         height_reg = HEIGHT_W'(1024);
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         foreach (window[r, c]) window[r][c] = '0;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         streaming = 0;
      endfunction

      function void write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
         case (index)
            REG_EDGE_MODE: mode = value[MODE_W-1:0];
            REG_FRAME_WIDTH: begin
               width_reg = value[WIDTH_W-1:0];
               clear_frame();
            end
            REG_FRAME_HEIGHT: begin
               height_reg = value[HEIGHT_W-1:0];
               clear_frame();
            end
            default: ;
         endcase
      endfunction

      function int clamp_mag(input int v);
         if (v < 0) v = -v;
         return (v > 255) ? 255 : v;
      endfunction

      function bit filter_step(input bit act, input pix_type pix, output edge_result_type res);
         int unsigned w, h, col;
         pix_type     v;
         bit          start_pt, off, emitted;
         int          sx, sy, sl, t, xp, yp;
         w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
         v = act ? '0 : pix;
         col = (in_col < MAX_WIDTH) ? in_col : 0;
         start_pt = (in_row == 1 && in_col == 0);
         emitted = 1'b0;
         res = '0;
         for (int r = 0; r < 3; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
         end
         window[0][2] = upper_row[col];
         window[1][2] = middle_row[col];
         window[2][2] = v;
         upper_row[col] = middle_row[col];
         middle_row[col] = v;
         if (streaming) begin
            emitted = 1'b1;
            sx = 0;
            sy = 0;
            sl = 0;
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  off = (r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                        (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w);
                  t = off ? 0 : int'(window[r][c]);
                  sl += (r == 1 && c == 1) ? 8 * t : -t;
                  if (mode == MODE_SOBEL) begin
                     sx += (c - 1) * ((r == 1) ? 2 : 1) * t;
                     sy += (r - 1) * ((c == 1) ? 2 : 1) * t;
                  end else begin
                     sx += (c - 1) * t;
                     sy += (r - 1) * t;
                  end
               end
            end
            if (mode == MODE_LAPLACE || mode == MODE_LAPLACE_ALT) begin
               res.edge_value = pix_type'((sl < 0) ? 0 : ((sl > 255) ? 255 : sl));
            end else begin
               xp = clamp_mag(sx);
               yp = clamp_mag(sy);
               res.x_part = pix_type'(xp);
               res.y_part = pix_type'(yp);
               res.edge_value = pix_type'((xp + yp > 255) ? 255 : xp + yp);
            end
            res.end_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
            if (res.end_of_frame) begin
               in_col = 0;
               in_row = 0;
               out_col = 0;
               out_row = 0;
               streaming = 0;
               return 1'b1;
            end
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               if (out_row < 'hFFF) out_row++;
            end
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            if (in_row < 'h1FFF) in_row++;
         end
         if (start_pt) streaming = 1;
         return emitted;
      endfunction

      function void note_item(input bit act, input pix_type pix);
         edge_result_type res;
         if (filter_step(act, pix, res)) expected_edges.push_back(res);
      endfunction

      function void check_result(input edge_result_type got);
         edge_result_type want;
         if (expected_edges.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: edge=%0d x=%0d y=%0d eof=%0d",
                        got.edge_value, got.x_part, got.y_part, got.end_of_frame);
            return;
         end
         want = expected_edges.pop_front();
         if (got != want) begin
            failures++;
            if (failures <= 10)
               $display({"result mismatch: expected edge=%0d x=%0d y=%0d eof=%0d,",
                         " got edge=%0d x=%0d y=%0d eof=%0d"},
                        want.edge_value, want.x_part, want.y_part, want.end_of_frame,
                        got.edge_value, got.x_part, got.y_part, got.end_of_frame);
         end
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_PIXEL;
   pix_type           req_pixel_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pix_type           rsp_edge_value, rsp_x_part, rsp_y_part;
   logic              rsp_end_of_frame;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   edge_scoreboard sb;
   int             item_count = 0;
   int             burst_left = 0;
   int             seg_left = 0;
   int             seg_pct = 0;
   logic           hold_request = 1'b0;
   logic           hold_done = 1'b0;
   int unsigned    cycle_count = 0;

   edge_detect_3x3_stream DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_edge_value(rsp_edge_value), .rsp_x_part(rsp_x_part),
      .rsp_y_part(rsp_y_part), .rsp_end_of_frame(rsp_end_of_frame),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin : result_monitor
      edge_result_type got;
      got = {rsp_edge_value, rsp_x_part, rsp_y_part, rsp_end_of_frame};
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(got);
   end

   // The receiver stalls in segments of random density, and once holds off long
   // enough for the block to fill up and stall its input.
   always begin : receiver_pattern
      @(posedge clock);
      if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         rsp_stall <= 1'b0;
         hold_done <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(5, 80);
            case ($urandom_range(0, 2))
               0: seg_pct = 0;
               1: seg_pct = 25;
               default: seg_pct = 70;
            endcase
         end
         seg_left--;
         rsp_stall <= ($urandom_range(0, 99) < seg_pct);
      end
   end

   task automatic send_item(input logic act, input pix_type pix);
      int gap;
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel_value <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(act, pix);
      item_count++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_PAD) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(index, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pix_type random_pixel();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   // One frame of w*h items followed by w+1 drain items; mostly pixels inside the
   // frame and flushes in the drain, with some of each mixed in. A cut index
   // stops the frame early.
   task automatic send_frame(input int w, input int h, input int cut);
      int  last;
      bit  act;
      last = (cut >= 0) ? cut : w * h + w + 1;
      for (int i = 0; i < last; i++) begin
         if (i < w * h) act = ($urandom_range(0, 19) == 0);
         else act = ($urandom_range(0, 4) != 0);
         send_item(act ? ACT_FLUSH : ACT_PIXEL, random_pixel());
      end
   endtask

   initial begin : stimulus
      int cur_w, cur_h, frames, phase, goal;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(REG_FRAME_WIDTH, 2);
      csr_write(REG_FRAME_HEIGHT, 2);
      send_item(ACT_PIXEL, 8'd255);
      send_item(ACT_PIXEL, 8'd0);
      send_item(ACT_PIXEL, 8'd0);
      send_item(ACT_PIXEL, 8'd255);
      repeat (3) send_item(ACT_FLUSH, 8'd255);
      wait_idle();

      // Flush inside the frame, then a pixel among the drain items.
      csr_write(REG_EDGE_MODE, MODE_PREWITT);
      send_item(ACT_PIXEL, 8'd0);
      send_item(ACT_PIXEL, 8'd255);
      send_item(ACT_FLUSH, 8'd255);
      send_item(ACT_PIXEL, 8'd255);
      send_item(ACT_PIXEL, 8'd255);
      send_item(ACT_FLUSH, 8'd0);
      send_item(ACT_FLUSH, 8'd0);
      wait_idle();

      csr_write(REG_EDGE_MODE, MODE_LAPLACE_ALT);
      send_item(ACT_PIXEL, 8'd255);
      send_item(ACT_PIXEL, 8'd0);
      send_item(ACT_PIXEL, 8'd0);
      send_item(ACT_PIXEL, 8'd255);
      repeat (3) send_item(ACT_FLUSH, 8'd0);
      wait_idle();

      // A geometry write in the middle of a frame restarts it; zero sizes act as one.
      csr_write(REG_EDGE_MODE, MODE_LAPLACE);
      send_item(ACT_PIXEL, 8'd255);
      send_item(ACT_PIXEL, 8'd255);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 0);
      csr_write(REG_FRAME_HEIGHT, 0);
      send_item(ACT_PIXEL, 8'd128);
      repeat (2) send_item(ACT_FLUSH, 8'd0);

      phase = 0;
      cur_w = 1;
      cur_h = 1;
      goal = item_count + RANDOM_GOAL;
      while (item_count < goal) begin
         wait_idle();
         csr_write(REG_EDGE_MODE, $urandom_range(0, 3));
         if (phase == 2 || $urandom_range(0, 4) != 0) begin
            if (phase == 2) begin
               cur_w = 8;
               cur_h = 6;
               hold_request <= 1'b1;
            end else begin
               cur_w = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
               cur_h = $urandom_range(1, 5);
            end
            csr_write(REG_FRAME_WIDTH, cur_w);
            csr_write(REG_FRAME_HEIGHT, cur_h);
         end
         frames = $urandom_range(1, 3);
         repeat (frames)
            send_frame(cur_w, cur_h,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_w * cur_h) : -1);
         phase++;
      end

      // Oversized registers clamp to the largest frame; only part of each frame is sent.
      wait_idle();
      csr_write(REG_EDGE_MODE, MODE_SOBEL);
      csr_write(REG_FRAME_HEIGHT, 2);
      csr_write(REG_FRAME_WIDTH, 2047);
      send_frame(MAX_WIDTH, 2, MAX_WIDTH + 40);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, 1);
      csr_write(REG_FRAME_HEIGHT, 8191);
      send_frame(1, MAX_HEIGHT, 24);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
      if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
